[rtl/datetime_difference_seconds_macros.svh]
// Assertion macros shared by the date-time difference checker.
`ifndef DATETIME_DIFFERENCE_SECONDS_MACROS_SVH
`define DATETIME_DIFFERENCE_SECONDS_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define DTDS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that stays active during reset.
`define DTDS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/dtds_pkg.sv]
// Shared widths, constants, stage-enable types and the month table.
`default_nettype none

package dtds_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int TOTAL_W  = 40;
    localparam int MDAYS_W  = 22;
    localparam int LDAYS_W  = 23;
    localparam int DD_W     = LDAYS_W + 1;
    localparam int HMS_W    = 17;

    localparam int LANE_STAGES  = 3;
    localparam int MERGE_STAGES = 6;
    localparam int STAGES       = LANE_STAGES + MERGE_STAGES;

    localparam logic [YEAR_W-1:0] MAX_YEAR          = 14'd9999;
    localparam logic [YEAR_W-1:0] YEARS_PER_CENTURY = 14'd100;

    localparam logic [HMS_W-1:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [HMS_W-1:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [HMS_W-1:0] SECS_PER_MIN  = 17'd60;

    // Reciprocal multipliers; each is exact over the operand range it sees.
    localparam logic [12:0] DIV100_MUL  = 13'd5243;
    localparam int          DIV100_SH   = 19;
    localparam logic [16:0] DIV3600_MUL = 17'd74566;
    localparam int          DIV3600_SH  = 28;
    localparam logic [12:0] DIV60_MUL   = 13'd4370;
    localparam int          DIV60_SH    = 18;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } lane_en_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } merge_en_t;

    // Days in the months before month m of a common year.
    function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [8:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd365;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

[rtl/datetime_difference_seconds.sv]
// Gregorian date-time difference in seconds: two conversion lanes and a merge pipeline.
//
// Input channel: in_valid / in_stall carry an end and a start date-time; a
// transfer happens at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry the signed difference end minus
// start, a negative flag, and the magnitude as days, hours, minutes, seconds.
// Years above 9999 are clamped; other fields are not range-checked and add their plain weight.
// From input transfer to result an item passes 3 stages in each of the
// two conversion lanes, which run side by side, and 6 merging stages.
// Throughput is one item per cycle while out_stall is low; every stage holds its own valid bit.
// When the receiver stalls, the output register holds its result and the
// stages behind it keep filling any empty slots, so new items are still taken
// until the pipeline is full; then in_stall rises.
// Reset clears all valid bits; no results are pending after reset and the
// block is ready to take an item when reset is released.
`default_nettype none

module datetime_difference_seconds
    import dtds_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [YEAR_W-1:0]  end_year,
    input  wire logic [MONTH_W-1:0] end_month,
    input  wire logic [DAY_W-1:0]   end_day,
    input  wire logic [HOUR_W-1:0]  end_hour,
    input  wire logic [MIN_W-1:0]   end_minute,
    input  wire logic [SEC_W-1:0]   end_second,
    input  wire logic [YEAR_W-1:0]  start_year,
    input  wire logic [MONTH_W-1:0] start_month,
    input  wire logic [DAY_W-1:0]   start_day,
    input  wire logic [HOUR_W-1:0]  start_hour,
    input  wire logic [MIN_W-1:0]   start_minute,
    input  wire logic [SEC_W-1:0]   start_second,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [TOTAL_W-1:0]      total_seconds,
    output logic                    is_negative,
    output logic [MDAYS_W-1:0]      magnitude_days,
    output logic [HOUR_W-1:0]       magnitude_hours,
    output logic [MIN_W-1:0]        magnitude_minutes,
    output logic [SEC_W-1:0]        magnitude_seconds
);

    logic [STAGES-1:0]  valid_reg, valid_next;
    logic [STAGES-1:0]  adv;
    lane_en_t           lane_en;
    merge_en_t          merge_en;
    logic [LDAYS_W-1:0] end_days, start_days;
    logic [HMS_W-1:0]   end_hms, start_hms;

    // A stage moves on when it is empty or the stage after it moves on.
    always_comb
    begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || !out_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next = {valid_reg[STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = valid_reg[STAGES-1];

    assign lane_en.s1  = adv[0];
    assign lane_en.s2  = adv[1];
    assign lane_en.s3  = adv[2];
    assign merge_en.s1 = adv[3];
    assign merge_en.s2 = adv[4];
    assign merge_en.s3 = adv[5];
    assign merge_en.s4 = adv[6];
    assign merge_en.s5 = adv[7];
    assign merge_en.s6 = adv[8];

    dtds_lane u_end_lane (
        .clk    (clk),
        .en     (lane_en),
        .year   (end_year),
        .month  (end_month),
        .day    (end_day),
        .hour   (end_hour),
        .minute (end_minute),
        .second (end_second),
        .days   (end_days),
        .hms    (end_hms)
    );

    dtds_lane u_start_lane (
        .clk    (clk),
        .en     (lane_en),
        .year   (start_year),
        .month  (start_month),
        .day    (start_day),
        .hour   (start_hour),
        .minute (start_minute),
        .second (start_second),
        .days   (start_days),
        .hms    (start_hms)
    );

    dtds_merge u_merge (
        .clk               (clk),
        .en                (merge_en),
        .end_days          (end_days),
        .end_hms           (end_hms),
        .start_days        (start_days),
        .start_hms         (start_hms),
        .total_seconds     (total_seconds),
        .is_negative       (is_negative),
        .magnitude_days    (magnitude_days),
        .magnitude_hours   (magnitude_hours),
        .magnitude_minutes (magnitude_minutes),
        .magnitude_seconds (magnitude_seconds)
    );

endmodule

`default_nettype wire

[rtl/dtds_lane.sv]
// One conversion lane: date-time to days since 0001-01-01 plus seconds of day.
`default_nettype none

module dtds_lane
    import dtds_pkg::*;
(
    input  wire logic               clk,
    input  wire lane_en_t           en,
    input  wire logic [YEAR_W-1:0]  year,
    input  wire logic [MONTH_W-1:0] month,
    input  wire logic [DAY_W-1:0]   day,
    input  wire logic [HOUR_W-1:0]  hour,
    input  wire logic [MIN_W-1:0]   minute,
    input  wire logic [SEC_W-1:0]   second,
    output logic [LDAYS_W-1:0]      days,
    output logic [HMS_W-1:0]        hms
);

    // Stage 1
    logic [YEAR_W-1:0]  ys_next, p_next;
    logic [26:0]        pq_prod_next, yq_prod_next;
    logic [21:0]        p365_next;
    logic [HMS_W-1:0]   hms_raw_next;

    logic [YEAR_W-1:0]  s1_ys_reg, s1_p_reg;
    logic [26:0]        s1_pq_prod_reg, s1_yq_prod_reg;
    logic [21:0]        s1_p365_reg;
    logic [8:0]         s1_dbm_reg;
    logic               s1_mge3_reg;
    logic [DAY_W-1:0]   s1_day_reg;
    logic [HMS_W-1:0]   s1_hms_reg;

    // Stage 2
    logic [7:0]         qp, qy;
    logic [YEAR_W-1:0]  ry;
    logic               leap;
    logic [21:0]        days_yr_next;
    logic [9:0]         dm_next;
    logic               carry_next;
    logic [HMS_W-1:0]   hms_norm_next;

    logic [21:0]        s2_days_yr_reg;
    logic [9:0]         s2_dm_reg;
    logic               s2_carry_reg;
    logic [HMS_W-1:0]   s2_hms_reg;

    // Stage 3
    logic [LDAYS_W-1:0] days_next;
    logic [LDAYS_W-1:0] s3_days_reg;
    logic [HMS_W-1:0]   s3_hms_reg;

    always_comb
    begin
        ys_next      = (year > MAX_YEAR) ? MAX_YEAR : year;
        p_next       = (ys_next != '0) ? ys_next - 14'd1 : '0;
        pq_prod_next = 27'(p_next) * 27'(DIV100_MUL);
        yq_prod_next = 27'(ys_next) * 27'(DIV100_MUL);
        p365_next    = 22'(p_next) * 22'd365;
        hms_raw_next = HMS_W'(hour) * SECS_PER_HOUR
                     + HMS_W'(minute) * SECS_PER_MIN
                     + HMS_W'(second);
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            s1_ys_reg      <= ys_next;
            s1_p_reg       <= p_next;
            s1_pq_prod_reg <= pq_prod_next;
            s1_yq_prod_reg <= yq_prod_next;
            s1_p365_reg    <= p365_next;
            s1_dbm_reg     <= days_before_month(month);
            s1_mge3_reg    <= (month >= 4'd3);
            s1_day_reg     <= day;
            s1_hms_reg     <= hms_raw_next;
        end
    end

    // Century counts come from the reciprocal products; the 400-year count
    // is the century count divided by four.
    always_comb
    begin
        qp   = s1_pq_prod_reg[DIV100_SH +: 8];
        qy   = s1_yq_prod_reg[DIV100_SH +: 8];
        ry   = s1_ys_reg - YEAR_W'(qy) * YEARS_PER_CENTURY;
        leap = ((s1_ys_reg[1:0] == 2'b00) && (ry != '0))
             || ((ry == '0) && (qy[1:0] == 2'b00));
        days_yr_next = s1_p365_reg + 22'(s1_p_reg[YEAR_W-1:2])
                     - 22'(qp) + 22'(qp[7:2]);
        dm_next    = 10'(s1_dbm_reg) + 10'(s1_day_reg) + 10'(s1_mge3_reg && leap);
        carry_next = (s1_hms_reg >= SECS_PER_DAY);
        hms_norm_next = carry_next ? s1_hms_reg - SECS_PER_DAY : s1_hms_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            s2_days_yr_reg <= days_yr_next;
            s2_dm_reg      <= dm_next;
            s2_carry_reg   <= carry_next;
            s2_hms_reg     <= hms_norm_next;
        end
    end

    // Day one of the month adds nothing, so one is taken off; the count can
    // reach minus one for day zero of the first year.
    always_comb
    begin
        days_next = LDAYS_W'({1'b0, s2_days_yr_reg}) + LDAYS_W'(s2_dm_reg)
                  + LDAYS_W'(s2_carry_reg) - LDAYS_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            s3_days_reg <= days_next;
            s3_hms_reg  <= s2_hms_reg;
        end
    end

    assign days = s3_days_reg;
    assign hms  = s3_hms_reg;

endmodule

`default_nettype wire

[rtl/dtds_merge.sv]
// Merging stages: difference of the two lanes and split of its magnitude.
`default_nettype none

module dtds_merge
    import dtds_pkg::*;
(
    input  wire logic               clk,
    input  wire merge_en_t          en,
    input  wire logic [LDAYS_W-1:0] end_days,
    input  wire logic [HMS_W-1:0]   end_hms,
    input  wire logic [LDAYS_W-1:0] start_days,
    input  wire logic [HMS_W-1:0]   start_hms,
    output logic [TOTAL_W-1:0]      total_seconds,
    output logic                    is_negative,
    output logic [MDAYS_W-1:0]      magnitude_days,
    output logic [HOUR_W-1:0]       magnitude_hours,
    output logic [MIN_W-1:0]        magnitude_minutes,
    output logic [SEC_W-1:0]        magnitude_seconds
);

    // Stage 1: day and second-of-day differences, second part made positive.
    logic [DD_W-1:0]    dd_raw, dd_next;
    logic [HMS_W:0]     hd_raw, hd_wrap;
    logic [HMS_W-1:0]   hd_next;
    logic [DD_W-1:0]    m1_dd_reg;
    logic [HMS_W-1:0]   m1_hd_reg;

    // Stage 2
    logic [TOTAL_W-1:0] dd_ext, total_next;
    logic               neg_next;
    logic [DD_W-1:0]    mdays_full;
    logic [HMS_W-1:0]   rem_next;
    logic [TOTAL_W-1:0] m2_total_reg;
    logic               m2_neg_reg;
    logic [MDAYS_W-1:0] m2_mdays_reg;
    logic [HMS_W-1:0]   m2_rem_reg;

    // Stage 3
    logic [33:0]        m3_hprod_reg;
    logic [TOTAL_W-1:0] m3_total_reg;
    logic               m3_neg_reg;
    logic [MDAYS_W-1:0] m3_mdays_reg;
    logic [HMS_W-1:0]   m3_rem_reg;

    // Stage 4
    logic [HOUR_W-1:0]  hr_next;
    logic [11:0]        r2_next;
    logic [HOUR_W-1:0]  m4_hr_reg;
    logic [11:0]        m4_r2_reg;
    logic [TOTAL_W-1:0] m4_total_reg;
    logic               m4_neg_reg;
    logic [MDAYS_W-1:0] m4_mdays_reg;

    // Stage 5
    logic [24:0]        m5_mprod_reg;
    logic [11:0]        m5_r2_reg;
    logic [HOUR_W-1:0]  m5_hr_reg;
    logic [TOTAL_W-1:0] m5_total_reg;
    logic               m5_neg_reg;
    logic [MDAYS_W-1:0] m5_mdays_reg;

    // Stage 6
    logic [MIN_W-1:0]   mn_next;
    logic [11:0]        min_secs;
    logic [TOTAL_W-1:0] m6_total_reg;
    logic               m6_neg_reg;
    logic [MDAYS_W-1:0] m6_mdays_reg;
    logic [HOUR_W-1:0]  m6_hr_reg;
    logic [MIN_W-1:0]   m6_mn_reg;
    logic [SEC_W-1:0]   m6_sec_reg;

    always_comb
    begin
        dd_raw  = {end_days[LDAYS_W-1], end_days} - {start_days[LDAYS_W-1], start_days};
        hd_raw  = {1'b0, end_hms} - {1'b0, start_hms};
        hd_wrap = hd_raw + (HMS_W+1)'(SECS_PER_DAY);
        dd_next = hd_raw[HMS_W] ? dd_raw - DD_W'(1) : dd_raw;
        hd_next = hd_raw[HMS_W] ? hd_wrap[HMS_W-1:0] : hd_raw[HMS_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            m1_dd_reg <= dd_next;
            m1_hd_reg <= hd_next;
        end
    end

    // With the second part in 0..86399 the sign of the total is the sign of
    // the day part; a negative total borrows one day when seconds remain.
    always_comb
    begin
        dd_ext     = {{(TOTAL_W-DD_W){m1_dd_reg[DD_W-1]}}, m1_dd_reg};
        total_next = dd_ext * TOTAL_W'(SECS_PER_DAY) + TOTAL_W'(m1_hd_reg);
        neg_next   = m1_dd_reg[DD_W-1];
        if (!neg_next)
        begin
            mdays_full = m1_dd_reg;
            rem_next   = m1_hd_reg;
        end
        else if (m1_hd_reg == '0)
        begin
            mdays_full = -m1_dd_reg;
            rem_next   = '0;
        end
        else
        begin
            mdays_full = ~m1_dd_reg;
            rem_next   = SECS_PER_DAY - m1_hd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            m2_total_reg <= total_next;
            m2_neg_reg   <= neg_next;
            m2_mdays_reg <= mdays_full[MDAYS_W-1:0];
            m2_rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            m3_hprod_reg <= 34'(m2_rem_reg) * 34'(DIV3600_MUL);
            m3_total_reg <= m2_total_reg;
            m3_neg_reg   <= m2_neg_reg;
            m3_mdays_reg <= m2_mdays_reg;
            m3_rem_reg   <= m2_rem_reg;
        end
    end

    always_comb
    begin
        hr_next = m3_hprod_reg[DIV3600_SH +: HOUR_W];
        r2_next = 12'(m3_rem_reg - HMS_W'(hr_next) * SECS_PER_HOUR);
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            m4_hr_reg    <= hr_next;
            m4_r2_reg    <= r2_next;
            m4_total_reg <= m3_total_reg;
            m4_neg_reg   <= m3_neg_reg;
            m4_mdays_reg <= m3_mdays_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            m5_mprod_reg <= 25'(m4_r2_reg) * 25'(DIV60_MUL);
            m5_r2_reg    <= m4_r2_reg;
            m5_hr_reg    <= m4_hr_reg;
            m5_total_reg <= m4_total_reg;
            m5_neg_reg   <= m4_neg_reg;
            m5_mdays_reg <= m4_mdays_reg;
        end
    end

    always_comb
    begin
        mn_next  = m5_mprod_reg[DIV60_SH +: MIN_W];
        min_secs = 12'(mn_next) * 12'(SECS_PER_MIN);
    end

    always_ff @(posedge clk)
    begin
        if (en.s6)
        begin
            m6_total_reg <= m5_total_reg;
            m6_neg_reg   <= m5_neg_reg;
            m6_mdays_reg <= m5_mdays_reg;
            m6_hr_reg    <= m5_hr_reg;
            m6_mn_reg    <= mn_next;
            m6_sec_reg   <= SEC_W'(m5_r2_reg - min_secs);
        end
    end

    assign total_seconds     = m6_total_reg;
    assign is_negative       = m6_neg_reg;
    assign magnitude_days    = m6_mdays_reg;
    assign magnitude_hours   = m6_hr_reg;
    assign magnitude_minutes = m6_mn_reg;
    assign magnitude_seconds = m6_sec_reg;

endmodule

`default_nettype wire

[rtl/dtds_checker.sv]
// Port-level checker for the date-time difference block, bound to the top level.
`default_nettype none

`include "datetime_difference_seconds_macros.svh"

module dtds_checker
    import dtds_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic [TOTAL_W-1:0] total_seconds,
    input wire logic               is_negative,
    input wire logic [MDAYS_W-1:0] magnitude_days,
    input wire logic [HOUR_W-1:0]  magnitude_hours,
    input wire logic [MIN_W-1:0]   magnitude_minutes,
    input wire logic [SEC_W-1:0]   magnitude_seconds
);

    // A stalled result stays on the port; its total and day count do not change.
    `DTDS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(total_seconds) && $stable(magnitude_days), "stalled result changed")

    // The negative flag follows the sign of the total.
    `DTDS_ASSERT(a_sign_match, out_valid |-> is_negative == total_seconds[TOTAL_W-1], "negative flag disagrees with total")

    // The split of the magnitude stays within a day.
    `DTDS_ASSERT(a_split_range, out_valid |-> magnitude_hours <= 5'd23 && magnitude_minutes <= 6'd59 && magnitude_seconds <= 6'd59, "magnitude split out of range")

    // No result is offered while reset is asserted.
    `DTDS_ASSERT_RST(a_reset_idle, !rst_n |-> !out_valid, "result offered during reset")

endmodule

bind datetime_difference_seconds dtds_checker u_dtds_checker (.*);

`default_nettype wire
